[rtl/edge_coverage_map_update_defines.svh]
// Assertion macros for the coverage map RTL.
`ifndef EDGE_COVERAGE_MAP_UPDATE_DEFINES_SVH
`define EDGE_COVERAGE_MAP_UPDATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ECM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecm assertion failed");

// Next-cycle implication, checked outside reset.
`define ECM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecm assertion failed");

`endif

[rtl/ecm_pkg.sv]
`default_nettype none
package ecm_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int INDEX_OUT_W = 16;
    localparam int COUNT_W     = 8;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRACE_ENABLE = 2'd0,
        CFG_COUNT_ALL    = 2'd1,
        CFG_WINDOW_START = 2'd2,
        CFG_WINDOW_END   = 2'd3
    } cfg_reg_t;

endpackage
`default_nettype wire

[rtl/ecm_ram.sv]
`default_nettype none
module ecm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port; a read at a written address sees old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/ecm_fifo.sv]
`default_nettype none
module ecm_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CntW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slots_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[rtl/ecm_front.sv]
`default_nettype none
module ecm_front #(
    parameter int MAP_BITS   = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ecm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ecm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [ecm_pkg::ADDR_W-1:0]         block_address,
    input  wire logic                               clear_busy,
    input  wire logic                               queue_full,
    output logic                                    push,
    output logic                                    push_take,
    output logic      [MAP_BITS-1:0]                push_idx
);

    localparam int AddrEff = (ADDR_WIDTH < ecm_pkg::ADDR_W) ? ADDR_WIDTH : ecm_pkg::ADDR_W;
    localparam logic [ecm_pkg::ADDR_W-1:0] AddrMask =
        {ecm_pkg::ADDR_W{1'b1}} >> (ecm_pkg::ADDR_W - AddrEff);

    logic                         trace_enable_reg;
    logic                         count_all_reg;
    logic [ecm_pkg::ADDR_W-1:0]   window_start_reg;
    logic [ecm_pkg::ADDR_W-1:0]   window_end_reg;
    logic [MAP_BITS-2:0]          prev_loc_reg;

    logic [ecm_pkg::ADDR_W-1:0]   addr;
    logic [ecm_pkg::ADDR_W-1:0]   folded;
    logic [MAP_BITS-1:0]          loc;
    logic                         outside;
    logic                         take;

    // classify: trace gate and inclusive address window
    assign addr    = block_address & AddrMask;
    assign outside = (addr < window_start_reg) || (addr > window_end_reg);
    assign take    = trace_enable_reg && (count_all_reg || !outside);

    // fold address to a map location, then form the edge index
    assign folded = (addr >> 16) ^ (addr >> 2) ^ {16'b0, addr[15:0]};
    assign loc    = folded[MAP_BITS-1:0];

    assign in_ready  = !clear_busy && !queue_full;
    assign push      = in_valid && in_ready;
    assign push_take = take;
    assign push_idx  = take ? (loc ^ {1'b0, prev_loc_reg}) : '0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_enable_reg <= 1'b0;
            count_all_reg    <= 1'b0;
            window_start_reg <= '0;
            window_end_reg   <= '1;
        end
        else if (cfg_we)
        begin
            case (ecm_pkg::cfg_reg_t'(cfg_index))
                ecm_pkg::CFG_TRACE_ENABLE: trace_enable_reg <= cfg_data[0];
                ecm_pkg::CFG_COUNT_ALL:    count_all_reg    <= cfg_data[0];
                ecm_pkg::CFG_WINDOW_START: window_start_reg <= cfg_data;
                ecm_pkg::CFG_WINDOW_END:   window_end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // previous location moves only on counted beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_loc_reg <= '0;
        end
        else if (push && take)
        begin
            prev_loc_reg <= loc[MAP_BITS-1:1];
        end
    end

endmodule
`default_nettype wire

[rtl/ecm_back.sv]
`default_nettype none
`include "edge_coverage_map_update_defines.svh"
module ecm_back #(
    parameter int MAP_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               queue_not_empty,
    input  wire logic                               queue_take,
    input  wire logic [MAP_BITS-1:0]                queue_idx,
    output logic                                    pop,
    output logic                                    clear_busy,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    counted,
    output logic      [ecm_pkg::INDEX_OUT_W-1:0]    map_index,
    output logic      [ecm_pkg::COUNT_W-1:0]        new_count
);

    localparam int CW = ecm_pkg::COUNT_W;

    // clearing pass
    logic                 clr_active_reg;
    logic [MAP_BITS-1:0]  clr_addr_reg;

    // update stage: read data valid, increment and write back
    logic                 u_valid_reg;
    logic                 u_take_reg;
    logic [MAP_BITS-1:0]  u_idx_reg;

    // forward of the write made at the same edge as the read
    logic                 fwd_valid_reg;
    logic [MAP_BITS-1:0]  fwd_idx_reg;
    logic [CW-1:0]        fwd_cnt_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_counted_reg;
    logic [MAP_BITS-1:0]  out_idx_reg;
    logic [CW-1:0]        out_count_reg;

    logic                 u_done;
    logic [CW-1:0]        rdata;
    logic [CW-1:0]        cur_cnt;
    logic [CW-1:0]        cnt;
    logic                 ram_we;
    logic [MAP_BITS-1:0]  ram_waddr;
    logic [CW-1:0]        ram_wdata;
    logic [MAP_BITS+ecm_pkg::INDEX_OUT_W-1:0] idx_ext;

    assign clear_busy = clr_active_reg;
    assign u_done     = u_valid_reg && (!out_valid_reg || out_ready);
    assign pop        = queue_not_empty && !clr_active_reg && (!u_valid_reg || u_done);

    // increment with forwarding
    assign cur_cnt = (fwd_valid_reg && fwd_idx_reg == u_idx_reg) ? fwd_cnt_reg : rdata;
    assign cnt     = cur_cnt + 1'b1;

    // write port: clearing pass or counter update
    assign ram_we    = clr_active_reg || (u_done && u_take_reg);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : u_idx_reg;
    assign ram_wdata = clr_active_reg ? '0 : cnt;

    ecm_ram #(
        .WIDTH (CW),
        .DEPTH (1 << MAP_BITS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (queue_idx),
        .rdata (rdata)
    );

    // clearing pass after reset, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            u_valid_reg   <= 1'b1;
            fwd_valid_reg <= u_done && u_take_reg;
        end
        else if (u_done)
        begin
            u_valid_reg <= 1'b0;
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            u_take_reg  <= queue_take;
            u_idx_reg   <= queue_idx;
            fwd_idx_reg <= u_idx_reg;
            fwd_cnt_reg <= cnt;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (u_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (u_done)
        begin
            out_counted_reg <= u_take_reg;
            out_idx_reg     <= u_take_reg ? u_idx_reg : '0;
            out_count_reg   <= u_take_reg ? cnt : '0;
        end
    end

    // map index port carries the low bits of the edge index
    assign idx_ext   = {{ecm_pkg::INDEX_OUT_W{1'b0}}, out_idx_reg};
    assign out_valid = out_valid_reg;
    assign counted   = out_counted_reg;
    assign map_index = idx_ext[ecm_pkg::INDEX_OUT_W-1:0];
    assign new_count = out_count_reg;

    `ECM_ASSERT_IMP(a_no_work_while_clearing, clk, rst_n, clr_active_reg, !u_valid_reg && !pop)
    `ECM_ASSERT_IMP(a_uncounted_is_zero, clk, rst_n, out_valid_reg && !out_counted_reg, out_idx_reg == '0 && out_count_reg == '0)
    `ECM_ASSERT_IMP(a_clear_covers_map, clk, rst_n, $fell(clr_active_reg), &$past(clr_addr_reg))

endmodule
`default_nettype wire

[rtl/edge_coverage_map_update.sv]
// Edge coverage map update.
// Input channel (in_valid/in_ready, block_address): one beat per executed code block.
// Output channel (out_valid/out_ready, counted, map_index, new_count): exactly one
// result beat per input beat, in order; uncounted beats report zeros.
// Configuration: cfg_we/cfg_index/cfg_data write trace_enable, count_all,
// window_start and window_end; write only while the block is idle.
// Throughput: one beat per cycle sustained while out_ready is high. The front
// classifies and forms the edge index in the accept cycle and pushes into a 4-entry
// queue; the back reads the counter RAM (registered read) and writes the incremented
// value back from the update stage, forwarding the previous write so back-to-back
// hits on one index count correctly. A result passes the queue, the update stage and
// the result register in that order. Reset: config registers and previous location
// go to their reset values, then a clearing pass zeroes all 2^MAP_BITS map entries
// (65536 at the default), during which in_ready is low. Config writes are taken
// during the pass. Stall: when out_ready is low the result register holds, the
// update stage holds, the queue fills, and in_ready drops once the queue is full.
`default_nettype none
module edge_coverage_map_update #(
    parameter int MAP_BITS   = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ecm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ecm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [ecm_pkg::ADDR_W-1:0]         block_address,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    counted,
    output logic      [ecm_pkg::INDEX_OUT_W-1:0]    map_index,
    output logic      [ecm_pkg::COUNT_W-1:0]        new_count
);

    localparam int QueueW = MAP_BITS + 1;

    logic                 clear_busy;
    logic                 queue_full;
    logic                 queue_not_empty;
    logic                 push;
    logic                 push_take;
    logic [MAP_BITS-1:0]  push_idx;
    logic                 pop;
    logic [QueueW-1:0]    pop_data;

    ecm_front #(
        .MAP_BITS   (MAP_BITS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .block_address (block_address),
        .clear_busy    (clear_busy),
        .queue_full    (queue_full),
        .push          (push),
        .push_take     (push_take),
        .push_idx      (push_idx)
    );

    ecm_fifo #(
        .WIDTH (QueueW),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_take, push_idx}),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (pop_data)
    );

    ecm_back #(
        .MAP_BITS (MAP_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_take      (pop_data[QueueW-1]),
        .queue_idx       (pop_data[MAP_BITS-1:0]),
        .pop             (pop),
        .clear_busy      (clear_busy),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .counted         (counted),
        .map_index       (map_index),
        .new_count       (new_count)
    );

endmodule
`default_nettype wire
